@@ rtl/keyed_compacting_table_sweep_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the keyed compacting table
// Implication checks sampled on the block clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEYED_COMPACTING_TABLE_SWEEP_ASSERT_SVH
`define KEYED_COMPACTING_TABLE_SWEEP_ASSERT_SVH

// same-cycle implication
`define KCTS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("keyed table assertion failed");

// next-cycle implication
`define KCTS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("keyed table assertion failed");

`endif

@@ rtl/kcts_pkg.sv @@
// ----------------------------------------------------------------------------
// kcts_pkg
// Operation and result codes and the table entry type.
// ----------------------------------------------------------------------------
package kcts_pkg;

   localparam logic [3:0] OP_UPSERT      = 4'd0;
   localparam logic [3:0] OP_REMOVE_ID   = 4'd1;
   localparam logic [3:0] OP_REMOVE_IDX  = 4'd2;
   localparam logic [3:0] OP_CLEAR       = 4'd3;
   localparam logic [3:0] OP_CLEAR_MARKS = 4'd4;
   localparam logic [3:0] OP_SET_MARKS   = 4'd5;
   localparam logic [3:0] OP_SWEEP       = 4'd6;
   localparam logic [3:0] OP_READ_IDX    = 4'd7;
   localparam logic [3:0] OP_LOOKUP      = 4'd8;
   localparam logic [3:0] OP_ADD         = 4'd9;
   localparam logic [3:0] OP_UPDATE      = 4'd10;

   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_ADDED   = 2'd1;
   localparam logic [1:0] KIND_MOVED   = 2'd2;
   localparam logic [1:0] KIND_REMOVED = 2'd3;

   localparam logic [8:0] HEADING_MAX = 9'd359;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] lon;
      logic [31:0] lat;
      logic [8:0]  head;
      logic [31:0] spd;
      logic [62:0] tim;
      logic        mark;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

@@ rtl/kcts_ram.sv @@
// ----------------------------------------------------------------------------
// kcts_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kcts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/keyed_compacting_table_sweep.sv @@
// ----------------------------------------------------------------------------
// keyed_compacting_table_sweep
// Insertion-ordered table keyed by id, with compaction and mark/sweep.
// ----------------------------------------------------------------------------
// One request transaction carries an operation and entry data; the block
// answers with zero or more event transactions (added, moved, removed) and
// one final status transaction with rsp_last high.
// The block takes one request at a time: req_ready is high only while idle.
// Entries sit in a single RAM with a registered read port; a sequencer walks
// the slots one at a time, each slot in an address state and then a data state.
// Searches, compaction after a removal, clear, mark updates and sweep all use
// this walk, so a request lasts longer as the fill count grows and while the
// receiver stalls. Read by index reads only the addressed slot; an unused
// op code goes straight to the status transaction.
// Compaction copies each kept slot down in the same walk as the read.
// A stalled receiver holds the walk at the slot whose event waits; the
// output register lets the walk run ahead by one transaction.
// Reset empties the table (fill count zero) and drops any pending result;
// RAM contents are not cleared and never read beyond the fill count.
// ----------------------------------------------------------------------------
`include "keyed_compacting_table_sweep_assert.svh"

module keyed_compacting_table_sweep #(
   parameter int DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_op,
   input  logic signed [31:0] req_user_id,
   input  logic [31:0]        req_longitude_bits,
   input  logic [31:0]        req_latitude_bits,
   input  logic [8:0]         req_heading,
   input  logic [31:0]        req_speed_bits,
   input  logic [62:0]        req_access_time,
   input  logic [4:0]         req_slot_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic               rsp_last,
   output logic               rsp_ok,
   output logic signed [31:0] rsp_entry_id,
   output logic [31:0]        rsp_entry_longitude,
   output logic [31:0]        rsp_entry_latitude,
   output logic [8:0]         rsp_entry_heading,
   output logic [31:0]        rsp_entry_speed,
   output logic [62:0]        rsp_entry_time,
   output logic               rsp_entry_marked,
   output logic [5:0]         rsp_entry_count,
   output logic [5:0]         rsp_removed_total
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > 5) ? CW : 5;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD   = 3'd1;
   localparam logic [2:0] ST_EV   = 3'd2;
   localparam logic [2:0] ST_ACT  = 3'd3;
   localparam logic [2:0] ST_STAT = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [3:0]          op_ff, op_in;
   kcts_pkg::entry_type nw_ff, nw_in;
   logic [4:0]          sidx_ff, sidx_in;
   logic [CW-1:0]       r_ff, r_in;
   logic [CW-1:0]       w_ff, w_in;
   logic [CW-1:0]       rem_ff, rem_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic                found_ff, found_in;
   logic                ok_ff, ok_in;
   kcts_pkg::entry_type st_ff, st_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_kind_ff, rsp_kind_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_ok_ff, rsp_ok_in;
   kcts_pkg::entry_type rsp_entry_ff, rsp_entry_in;
   logic [CW-1:0]       rsp_count_ff, rsp_count_in;
   logic [CW-1:0]       rsp_rem_ff, rsp_rem_in;

   logic                        wr_en;
   logic [IW-1:0]               wr_addr;
   kcts_pkg::entry_type         wr_data;
   logic [IW-1:0]               rd_addr;
   logic [kcts_pkg::ENTRY_W-1:0] rd_word;
   kcts_pkg::entry_type         rd_entry;

   logic rsp_free;
   logic is_find;
   logic is_compact;
   logic drop;
   logic do_upd;
   logic do_add;

   kcts_ram #(
      .WIDTH (kcts_pkg::ENTRY_W),
      .DEPTH (DEPTH),
      .AW    (IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_entry = kcts_pkg::entry_type'(rd_word);
   assign rd_addr  = r_ff[IW-1:0];
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   assign is_find = (op_ff == kcts_pkg::OP_UPSERT) || (op_ff == kcts_pkg::OP_LOOKUP) ||
                    (op_ff == kcts_pkg::OP_ADD) || (op_ff == kcts_pkg::OP_UPDATE);
   assign is_compact = (op_ff == kcts_pkg::OP_REMOVE_ID) || (op_ff == kcts_pkg::OP_REMOVE_IDX) ||
                       (op_ff == kcts_pkg::OP_CLEAR) || (op_ff == kcts_pkg::OP_CLEAR_MARKS) ||
                       (op_ff == kcts_pkg::OP_SET_MARKS) || (op_ff == kcts_pkg::OP_SWEEP);

   always_comb begin
      case (op_ff)
         kcts_pkg::OP_REMOVE_ID:  drop = (rd_entry.id == nw_ff.id) && (rem_ff == '0);
         kcts_pkg::OP_REMOVE_IDX: drop = (XW'(r_ff) == XW'(sidx_ff));
         kcts_pkg::OP_CLEAR:      drop = 1'b1;
         kcts_pkg::OP_SWEEP:      drop = !rd_entry.mark;
         default:                 drop = 1'b0;
      endcase
   end

   assign do_upd = (op_ff != kcts_pkg::OP_ADD) && found_ff;
   assign do_add = (op_ff != kcts_pkg::OP_UPDATE) && !found_ff && (fill_ff < CW'(DEPTH));

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      nw_in        = nw_ff;
      sidx_in      = sidx_ff;
      r_in         = r_ff;
      w_in         = w_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      found_in     = found_ff;
      ok_in        = ok_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_count_in = rsp_count_ff;
      rsp_rem_in   = rsp_rem_ff;
      wr_en        = 1'b0;
      wr_addr      = w_ff[IW-1:0];
      wr_data      = rd_entry;
      req_ready    = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in      = req_op;
               nw_in.id   = req_user_id;
               nw_in.lon  = req_longitude_bits;
               nw_in.lat  = req_latitude_bits;
               nw_in.head = (req_heading > kcts_pkg::HEADING_MAX) ?
                            kcts_pkg::HEADING_MAX : req_heading;
               nw_in.spd  = req_speed_bits;
               nw_in.tim  = req_access_time;
               nw_in.mark = 1'b1;
               sidx_in    = req_slot_index;
               r_in       = '0;
               w_in       = '0;
               rem_in     = '0;
               found_in   = 1'b0;
               ok_in      = 1'b0;
               st_in      = '0;
               if (req_op == kcts_pkg::OP_READ_IDX) begin
                  if (XW'(req_slot_index) < XW'(fill_ff)) begin
                     r_in     = CW'(req_slot_index);
                     state_in = ST_RD;
                  end else begin
                     state_in = ST_STAT;
                  end
               end else if (req_op > kcts_pkg::OP_UPDATE) begin
                  state_in = ST_STAT;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            if (op_ff == kcts_pkg::OP_READ_IDX || r_ff < fill_ff) begin
               state_in = ST_EV;
            end else if (is_find) begin
               state_in = ST_ACT;
            end else begin
               fill_in  = fill_ff - rem_ff;
               ok_in    = ((op_ff != kcts_pkg::OP_REMOVE_ID) &&
                           (op_ff != kcts_pkg::OP_REMOVE_IDX)) || (rem_ff != '0);
               state_in = ST_STAT;
            end
         end
         ST_EV: begin
            if (op_ff == kcts_pkg::OP_READ_IDX) begin
               st_in    = rd_entry;
               ok_in    = 1'b1;
               state_in = ST_STAT;
            end else if (is_find) begin
               if (rd_entry.id == nw_ff.id) begin
                  found_in = 1'b1;
                  idx_in   = r_ff;
                  if (op_ff == kcts_pkg::OP_LOOKUP) begin
                     st_in = rd_entry;
                     ok_in = 1'b1;
                  end
                  state_in = ST_ACT;
               end else begin
                  r_in     = r_ff + 1'b1;
                  state_in = ST_RD;
               end
            end else if (is_compact) begin
               if (drop) begin
                  if (rsp_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = kcts_pkg::KIND_REMOVED;
                     rsp_last_in  = 1'b0;
                     rsp_ok_in    = 1'b1;
                     rsp_entry_in = rd_entry;
                     rsp_count_in = fill_ff - rem_ff - 1'b1;
                     rsp_rem_in   = rem_ff + 1'b1;
                     rem_in       = rem_ff + 1'b1;
                     if (op_ff == kcts_pkg::OP_REMOVE_ID || op_ff == kcts_pkg::OP_REMOVE_IDX) begin
                        st_in = rd_entry;
                     end
                     r_in     = r_ff + 1'b1;
                     state_in = ST_RD;
                  end
               end else begin
                  wr_en = 1'b1;
                  if (op_ff == kcts_pkg::OP_CLEAR_MARKS) begin
                     wr_data.mark = 1'b0;
                  end else if (op_ff == kcts_pkg::OP_SET_MARKS) begin
                     wr_data.mark = 1'b1;
                  end
                  w_in     = w_ff + 1'b1;
                  r_in     = r_ff + 1'b1;
                  state_in = ST_RD;
               end
            end else begin
               state_in = ST_STAT;
            end
         end
         ST_ACT: begin
            if (op_ff == kcts_pkg::OP_LOOKUP || !(do_upd || do_add)) begin
               state_in = ST_STAT;
            end else if (rsp_free) begin
               wr_en        = 1'b1;
               wr_addr      = do_upd ? idx_ff[IW-1:0] : fill_ff[IW-1:0];
               wr_data      = nw_ff;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = do_upd ? kcts_pkg::KIND_MOVED : kcts_pkg::KIND_ADDED;
               rsp_last_in  = 1'b0;
               rsp_ok_in    = 1'b1;
               rsp_entry_in = nw_ff;
               rsp_count_in = do_upd ? fill_ff : fill_ff + 1'b1;
               rsp_rem_in   = '0;
               if (do_add) begin
                  fill_in = fill_ff + 1'b1;
               end
               st_in    = nw_ff;
               ok_in    = 1'b1;
               state_in = ST_STAT;
            end
         end
         ST_STAT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kcts_pkg::KIND_STATUS;
               rsp_last_in  = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_entry_in = st_ff;
               rsp_count_in = fill_ff;
               rsp_rem_in   = rem_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      nw_ff        <= nw_in;
      sidx_ff      <= sidx_in;
      r_ff         <= r_in;
      w_ff         <= w_in;
      rem_ff       <= rem_in;
      idx_ff       <= idx_in;
      found_ff     <= found_in;
      ok_ff        <= ok_in;
      st_ff        <= st_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_count_ff <= rsp_count_in;
      rsp_rem_ff   <= rsp_rem_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_ok              = rsp_ok_ff;
   assign rsp_entry_id        = rsp_entry_ff.id;
   assign rsp_entry_longitude = rsp_entry_ff.lon;
   assign rsp_entry_latitude  = rsp_entry_ff.lat;
   assign rsp_entry_heading   = rsp_entry_ff.head;
   assign rsp_entry_speed     = rsp_entry_ff.spd;
   assign rsp_entry_time      = rsp_entry_ff.tim;
   assign rsp_entry_marked    = rsp_entry_ff.mark;
   assign rsp_entry_count     = 6'(rsp_count_ff);
   assign rsp_removed_total   = 6'(rsp_rem_ff);

   `KCTS_ASSERT_IMPL(a_fill_bound, 1'b1, fill_ff <= CW'(DEPTH))
   `KCTS_ASSERT_NEXT(a_accept_busy, req_valid && req_ready, state_ff != ST_IDLE)
   `KCTS_ASSERT_IMPL(a_compact_order, state_ff == ST_EV, w_ff <= r_ff)
   `KCTS_ASSERT_IMPL(a_last_is_status, rsp_valid_ff && rsp_last_ff,
                     rsp_kind_ff == kcts_pkg::KIND_STATUS)

endmodule

@@ test/keyed_compacting_table_sweep_test.sv @@
// ----------------------------------------------------------------------------
// keyed_compacting_table_sweep_test
// Self-checking bench for the keyed table: a queue-fed driver, a monitor and
// a behavioural table model that predicts every event and status transaction.
// ----------------------------------------------------------------------------
module keyed_compacting_table_sweep_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 32;

   typedef struct packed {
      logic [3:0]  op;
      logic [31:0] user_id;
      logic [31:0] lon;
      logic [31:0] lat;
      logic [8:0]  head;
      logic [31:0] spd;
      logic [62:0] tim;
      logic [4:0]  slot;
   } request_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic                last;
      logic                ok;
      kcts_pkg::entry_type ent;
      logic [5:0]          count;
      logic [5:0]          removed;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [3:0] req_op = '0;
   logic signed [31:0] req_user_id = '0;
   logic [31:0] req_longitude_bits = '0, req_latitude_bits = '0, req_speed_bits = '0;
   logic [8:0] req_heading = '0;
   logic [62:0] req_access_time = '0;
   logic [4:0] req_slot_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_kind;
   logic rsp_last, rsp_ok, rsp_entry_marked;
   logic signed [31:0] rsp_entry_id;
   logic [31:0] rsp_entry_longitude, rsp_entry_latitude, rsp_entry_speed;
   logic [8:0] rsp_entry_heading;
   logic [62:0] rsp_entry_time;
   logic [5:0] rsp_entry_count, rsp_removed_total;

   keyed_compacting_table_sweep #(.DEPTH(DEPTH)) dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   request_type         pending_reqs[$];
   answer_type          expected_answers[$];
   kcts_pkg::entry_type table_model[DEPTH];
   int                  fill_model = 0;
   int                  errors = 0;
   int                  cycle = 0;
   bit                  calm = 1'b0;
   int                  id_pool[8];

   task automatic report_mismatch(input string what);
      errors++;
      $display("mismatch at cycle %0d: %s", cycle, what);
   endtask

   function automatic void push_answer(logic [1:0] k, logic l, logic o,
                                       kcts_pkg::entry_type e, int rem);
      answer_type a;
      a.kind = k; a.last = l; a.ok = o; a.ent = e;
      a.count = fill_model[5:0]; a.removed = rem[5:0];
      expected_answers.push_back(a);
   endfunction

   function automatic int find_key(logic [31:0] id);
      for (int i = 0; i < fill_model; i++)
         if (table_model[i].id == id) return i;
      return -1;
   endfunction

   function automatic void drop_entry(int i);
      for (int j = i; j + 1 < fill_model; j++) table_model[j] = table_model[j + 1];
      fill_model--;
   endfunction

   function automatic void predict_table(request_type r);
      kcts_pkg::entry_type nw, st, s;
      logic ok;
      int i, rem;
      st = '0; ok = 1'b0; rem = 0;
      nw.id = r.user_id; nw.lon = r.lon; nw.lat = r.lat;
      nw.head = (r.head > kcts_pkg::HEADING_MAX) ? kcts_pkg::HEADING_MAX : r.head;
      nw.spd = r.spd; nw.tim = r.tim; nw.mark = 1'b1;
      case (r.op)
         kcts_pkg::OP_UPSERT, kcts_pkg::OP_ADD, kcts_pkg::OP_UPDATE: begin
            i = find_key(r.user_id);
            if (r.op != kcts_pkg::OP_ADD && i >= 0) begin
               table_model[i] = nw;
               push_answer(kcts_pkg::KIND_MOVED, 1'b0, 1'b1, nw, 0);
               st = nw; ok = 1'b1;
            end else if (r.op != kcts_pkg::OP_UPDATE && i < 0 && fill_model < DEPTH) begin
               table_model[fill_model] = nw;
               fill_model++;
               push_answer(kcts_pkg::KIND_ADDED, 1'b0, 1'b1, nw, 0);
               st = nw; ok = 1'b1;
            end
         end
         kcts_pkg::OP_REMOVE_ID, kcts_pkg::OP_REMOVE_IDX: begin
            i = (r.op == kcts_pkg::OP_REMOVE_ID) ? find_key(r.user_id) : int'(r.slot);
            if (i >= 0 && i < fill_model) begin
               st = table_model[i];
               drop_entry(i);
               rem = 1;
               push_answer(kcts_pkg::KIND_REMOVED, 1'b0, 1'b1, st, rem);
               ok = 1'b1;
            end
         end
         kcts_pkg::OP_CLEAR: begin
            while (fill_model > 0) begin
               s = table_model[0];
               drop_entry(0);
               rem++;
               push_answer(kcts_pkg::KIND_REMOVED, 1'b0, 1'b1, s, rem);
            end
            ok = 1'b1;
         end
         kcts_pkg::OP_CLEAR_MARKS, kcts_pkg::OP_SET_MARKS: begin
            for (int j = 0; j < fill_model; j++)
               table_model[j].mark = (r.op == kcts_pkg::OP_SET_MARKS);
            ok = 1'b1;
         end
         kcts_pkg::OP_SWEEP: begin
            i = 0;
            while (i < fill_model) begin
               if (table_model[i].mark) i++;
               else begin
                  s = table_model[i];
                  drop_entry(i);
                  rem++;
                  push_answer(kcts_pkg::KIND_REMOVED, 1'b0, 1'b1, s, rem);
               end
            end
            ok = 1'b1;
         end
         kcts_pkg::OP_READ_IDX, kcts_pkg::OP_LOOKUP: begin
            i = (r.op == kcts_pkg::OP_READ_IDX) ? int'(r.slot) : find_key(r.user_id);
            if (i >= 0 && i < fill_model) begin
               st = table_model[i]; ok = 1'b1;
            end
         end
         default: ;
      endcase
      push_answer(kcts_pkg::KIND_STATUS, 1'b1, ok, st, rem);
   endfunction

   function automatic request_type make_req(logic [3:0] op, logic [31:0] id);
      request_type r;
      r.op = op; r.user_id = id;
      r.lon = $urandom; r.lat = $urandom; r.spd = $urandom;
      r.head = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(0, 359));
      r.tim = 63'({$urandom, $urandom});
      r.slot = 5'($urandom);
      return r;
   endfunction

   function automatic logic [31:0] pick_id();
      return ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'(id_pool[$urandom_range(0, 7)]);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 12)) begin
            request_type r;
            r = pending_reqs.pop_front();
            predict_table(r);
            req_valid <= 1'b1;
            req_op <= r.op; req_user_id <= r.user_id;
            req_longitude_bits <= r.lon; req_latitude_bits <= r.lat;
            req_heading <= r.head; req_speed_bits <= r.spd;
            req_access_time <= r.tim; req_slot_index <= r.slot;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (!reset) begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 12);
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               report_mismatch("unexpected result transaction");
            end else begin
               answer_type a;
               a = expected_answers.pop_front();
               if (rsp_kind !== a.kind) report_mismatch("kind");
               if (rsp_last !== a.last) report_mismatch("last");
               if (rsp_ok !== a.ok) report_mismatch("ok");
               if (rsp_entry_id !== a.ent.id) report_mismatch("entry_id");
               if (rsp_entry_longitude !== a.ent.lon) report_mismatch("entry_longitude");
               if (rsp_entry_latitude !== a.ent.lat) report_mismatch("entry_latitude");
               if (rsp_entry_heading !== a.ent.head) report_mismatch("entry_heading");
               if (rsp_entry_speed !== a.ent.spd) report_mismatch("entry_speed");
               if (rsp_entry_time !== a.ent.tim) report_mismatch("entry_time");
               if (rsp_entry_marked !== a.ent.mark) report_mismatch("entry_marked");
               if (rsp_entry_count !== a.count) report_mismatch("entry_count");
               if (rsp_removed_total !== a.removed) report_mismatch("removed_total");
            end
         end
      end
      if (cycle > 400000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      request_type r;
      int roll;
      foreach (id_pool[k]) id_pool[k] = $urandom;
      id_pool[0] = 32'h8000_0000;
      id_pool[1] = 32'h7fff_ffff;
      // directed
      pending_reqs.push_back(make_req(kcts_pkg::OP_READ_IDX, 0));
      pending_reqs.push_back(make_req(kcts_pkg::OP_SWEEP, 0));
      pending_reqs.push_back(make_req(kcts_pkg::OP_CLEAR, 0));
      r = make_req(kcts_pkg::OP_ADD, id_pool[0]);
      r.lon = '0; r.lat = '1; r.spd = '0; r.head = 9'h1ff; r.tim = '1;
      pending_reqs.push_back(r);
      r = make_req(kcts_pkg::OP_ADD, id_pool[1]);
      r.lon = '1; r.lat = '0; r.spd = '1; r.head = '0; r.tim = '0;
      pending_reqs.push_back(r);
      pending_reqs.push_back(make_req(kcts_pkg::OP_ADD, id_pool[1]));
      pending_reqs.push_back(make_req(kcts_pkg::OP_UPDATE, 32'h1234));
      pending_reqs.push_back(make_req(kcts_pkg::OP_UPDATE, id_pool[0]));
      pending_reqs.push_back(make_req(kcts_pkg::OP_UPSERT, id_pool[2]));
      pending_reqs.push_back(make_req(kcts_pkg::OP_UPSERT, id_pool[2]));
      pending_reqs.push_back(make_req(kcts_pkg::OP_LOOKUP, id_pool[1]));
      pending_reqs.push_back(make_req(kcts_pkg::OP_LOOKUP, 32'h1234));
      pending_reqs.push_back(make_req(kcts_pkg::OP_CLEAR_MARKS, 0));
      pending_reqs.push_back(make_req(kcts_pkg::OP_UPDATE, id_pool[1]));
      pending_reqs.push_back(make_req(kcts_pkg::OP_SWEEP, 0));
      pending_reqs.push_back(make_req(kcts_pkg::OP_SET_MARKS, 0));
      r = make_req(kcts_pkg::OP_REMOVE_IDX, 0); r.slot = 5'd31; pending_reqs.push_back(r);
      pending_reqs.push_back(make_req(kcts_pkg::OP_REMOVE_ID, 32'h1234));
      pending_reqs.push_back(make_req(kcts_pkg::OP_REMOVE_ID, id_pool[2]));
      for (int k = 0; k < 33; k++)
         pending_reqs.push_back(make_req(kcts_pkg::OP_ADD, 32'(k * 7 + 1)));
      r = make_req(kcts_pkg::OP_READ_IDX, 0); r.slot = 5'd31; pending_reqs.push_back(r);
      pending_reqs.push_back(make_req(kcts_pkg::OP_CLEAR, 0));
      pending_reqs.push_back(make_req(4'd11, 0));
      pending_reqs.push_back(make_req(4'd15, 0));
      // random
      for (int n = 0; n < 355; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 40) r = make_req(kcts_pkg::OP_UPSERT, pick_id());
         else if (roll < 50)
            r = make_req(kcts_pkg::OP_ADD, ($urandom_range(0, 1)) ? pick_id() : $urandom);
         else if (roll < 56) r = make_req(kcts_pkg::OP_UPDATE, pick_id());
         else if (roll < 63) r = make_req(kcts_pkg::OP_REMOVE_ID, pick_id());
         else if (roll < 69) r = make_req(kcts_pkg::OP_REMOVE_IDX, 0);
         else if (roll < 72) r = make_req(kcts_pkg::OP_CLEAR, 0);
         else if (roll < 77) r = make_req(kcts_pkg::OP_CLEAR_MARKS, 0);
         else if (roll < 80) r = make_req(kcts_pkg::OP_SET_MARKS, 0);
         else if (roll < 86) r = make_req(kcts_pkg::OP_SWEEP, 0);
         else if (roll < 91) r = make_req(kcts_pkg::OP_READ_IDX, 0);
         else if (roll < 97) r = make_req(kcts_pkg::OP_LOOKUP, pick_id());
         else r = make_req(4'($urandom_range(11, 15)), pick_id());
         if (r.op == kcts_pkg::OP_REMOVE_IDX || r.op == kcts_pkg::OP_READ_IDX)
            r.slot = 5'($urandom_range(0, 31));
         pending_reqs.push_back(r);
         if (n % 64 == 0) id_pool[$urandom_range(2, 7)] = $urandom;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (pending_reqs.size() == 100);
      calm = 1'b1;
      wait (pending_reqs.size() == 40);
      calm = 1'b0;
      wait (pending_reqs.size() == 0 && !req_valid && expected_answers.size() == 0);
      repeat (80) @(posedge clock);
      if (errors == 0 && expected_answers.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

@@ keyed_compacting_table_sweep.f @@
+incdir+rtl
rtl/kcts_pkg.sv
rtl/kcts_ram.sv
rtl/keyed_compacting_table_sweep.sv
test/keyed_compacting_table_sweep_test.sv
